/* rtl/core/crfs_pkg.sv */
`default_nettype none
package crfs_pkg;

   // CRC-16 (Modbus): init all ones, reflected polynomial, no final xor
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // Shortest frame: one address byte plus the two CRC bytes
   localparam logic [15:0] MinFrameBytes = 16'd3;

   // Reset value of the max_frames register
   localparam logic [15:0] MaxFramesReset = 16'd100;

   // Response record kinds
   localparam logic KindFrame   = 1'b0;
   localparam logic KindSummary = 1'b1;

   // Response queue geometry (entries hold all results of one input byte)
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = 1;
   localparam int QueueCntW  = 2;

   // All results caused by one input byte
   typedef struct packed {
      logic        has_frame;
      logic        has_summary;
      logic [15:0] frame_offset;
      logic [15:0] frame_length;
      logic [15:0] frame_count;
      logic [15:0] summary_count;
   } item_rec_type;

   // Splitter to queue push
   typedef struct packed {
      logic         valid;
      item_rec_type rec;
   } push_type;

   // One byte of the reflected CRC, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/crfs_req_if.sv */
`default_nettype none
interface crfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/crfs_rsp_if.sv */
`default_nettype none
interface crfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [15:0] frame_offset;
   logic [15:0] frame_length;
   logic [15:0] frame_count;
   logic        last_result;

   modport source (output valid, output record_kind, output frame_offset,
                   output frame_length, output frame_count, output last_result,
                   input ready);
   modport sink   (input valid, input record_kind, input frame_offset,
                   input frame_length, input frame_count, input last_result,
                   output ready);
endinterface
`default_nettype wire

/* rtl/core/crfs_splitter.sv */
`default_nettype none
module crfs_splitter (
   input  wire logic          clock,
   input  wire logic          reset,
   crfs_req_if.sink           req_bus,
   input  wire logic [15:0]   max_frames,
   input  wire logic          q_room,
   output crfs_pkg::push_type push
);

   // Input register
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_byte_ff;
   logic       a_last_ff;
   logic       req_take;
   logic       a_go;

   // Per-buffer state
   logic [15:0] crc_ff, crc_in;
   logic [15:0] bif_ff, bif_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] frames_ff, frames_in;
   logic        stopped_ff, stopped_in;

   logic [15:0] crc_new;
   logic [15:0] bif_new;
   logic [15:0] frames_inc;
   logic [15:0] pos_inc;
   logic        found;
   logic        emit_frame;

   // Input handshake: the stage frees up whenever the queue has room
   assign a_go          = a_valid_ff & q_room;
   assign req_bus.ready = ~a_valid_ff | q_room;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_take) begin
         a_byte_ff <= req_bus.data_byte;
         a_last_ff <= req_bus.last_byte;
      end
   end

   // CRC update and frame end detection
   assign crc_new    = stopped_ff ? crc_ff : crfs_pkg::crc_byte(crc_ff, a_byte_ff);
   assign bif_new    = (bif_ff == 16'hFFFF) ? bif_ff : bif_ff + 16'd1;
   assign frames_inc = frames_ff + 16'd1;
   assign pos_inc    = pos_ff + 16'd1;
   assign found      = ~stopped_ff & (bif_new >= crfs_pkg::MinFrameBytes) &
                       (crc_new == 16'h0000);
   assign emit_frame = found & (frames_ff < max_frames);

   // Next state
   always_comb begin
      crc_in     = crc_ff;
      bif_in     = bif_ff;
      start_in   = start_ff;
      pos_in     = pos_ff;
      frames_in  = frames_ff;
      stopped_in = stopped_ff;
      if (a_go) begin
         pos_in = pos_inc;
         if (!stopped_ff) begin
            crc_in = crc_new;
            bif_in = bif_new;
         end
         if (emit_frame) begin
            frames_in = frames_inc;
            start_in  = pos_inc;
            bif_in    = 16'd0;
            crc_in    = crfs_pkg::CrcInit;
         end else if (found) begin
            stopped_in = 1'b1;
         end
         // end of buffer: everything back to reset values
         if (a_last_ff) begin
            crc_in     = crfs_pkg::CrcInit;
            bif_in     = 16'd0;
            start_in   = 16'd0;
            pos_in     = 16'd0;
            frames_in  = 16'd0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= crfs_pkg::CrcInit;
         bif_ff     <= 16'd0;
         start_ff   <= 16'd0;
         pos_ff     <= 16'd0;
         frames_ff  <= 16'd0;
         stopped_ff <= 1'b0;
      end else begin
         crc_ff     <= crc_in;
         bif_ff     <= bif_in;
         start_ff   <= start_in;
         pos_ff     <= pos_in;
         frames_ff  <= frames_in;
         stopped_ff <= stopped_in;
      end
   end

   // Results of this byte go to the queue as one entry
   always_comb begin
      push.valid             = a_go & (emit_frame | a_last_ff);
      push.rec.has_frame     = emit_frame;
      push.rec.has_summary   = a_last_ff;
      push.rec.frame_offset  = start_ff;
      push.rec.frame_length  = bif_new;
      push.rec.frame_count   = frames_inc;
      push.rec.summary_count = emit_frame ? frames_inc : frames_ff;
   end

   // A processed last byte leaves the buffer state cleared
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      a_go && a_last_ff |=> pos_ff == 16'd0 && frames_ff == 16'd0 && !stopped_ff)
      else $error("state not cleared after last byte");

   // Splitting stays stopped until the buffer ends
   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      stopped_ff && !(a_go && a_last_ff) |=> stopped_ff)
      else $error("splitting resumed before end of buffer");

endmodule
`default_nettype wire

/* rtl/core/crfs_rsp_queue.sv */
`default_nettype none
module crfs_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire crfs_pkg::push_type  push,
   output logic                     q_room,
   crfs_rsp_if.source               rsp_bus
);

   crfs_pkg::item_rec_type q_ff [crfs_pkg::QueueDepth];
   logic [crfs_pkg::QueuePtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [crfs_pkg::QueueCntW-1:0] q_count_ff, q_count_in;
   logic                           phase_ff, phase_in;

   crfs_pkg::item_rec_type head;
   logic                   show_sum;
   logic                   rsp_take;
   logic                   pop_entry;

   // Room for one more entry, from registers only
   assign q_room = (q_count_ff < crfs_pkg::QueueCntW'(crfs_pkg::QueueDepth));

   // Head entry: frame record first, then the summary
   assign head      = q_ff[rd_ptr_ff];
   assign show_sum  = ~head.has_frame | phase_ff;
   assign rsp_take  = rsp_bus.valid & rsp_bus.ready;
   assign pop_entry = rsp_take & (show_sum | ~head.has_summary);

   assign rsp_bus.valid        = (q_count_ff != '0);
   assign rsp_bus.record_kind  = show_sum ? crfs_pkg::KindSummary : crfs_pkg::KindFrame;
   assign rsp_bus.frame_offset = show_sum ? 16'd0 : head.frame_offset;
   assign rsp_bus.frame_length = show_sum ? 16'd0 : head.frame_length;
   assign rsp_bus.frame_count  = show_sum ? head.summary_count : head.frame_count;
   assign rsp_bus.last_result  = show_sum | ~head.has_summary;

   always_comb begin
      phase_in = phase_ff;
      if (pop_entry) begin
         phase_in = 1'b0;
      end else if (rsp_take) begin
         phase_in = 1'b1;
      end
      q_count_in = q_count_ff + {{(crfs_pkg::QueueCntW-1){1'b0}}, push.valid}
                              - {{(crfs_pkg::QueueCntW-1){1'b0}}, pop_entry};
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         phase_ff   <= 1'b0;
      end else begin
         q_count_ff <= q_count_in;
         phase_ff   <= phase_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_entry) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_ff[wr_ptr_ff] <= push.rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> q_count_ff != crfs_pkg::QueueCntW'(crfs_pkg::QueueDepth))
      else $error("push into full response queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= crfs_pkg::QueueCntW'(crfs_pkg::QueueDepth))
      else $error("response queue count out of range");

endmodule
`default_nettype wire

/* rtl/core/crc_residue_frame_splitter_top.sv */
// An accepted byte waits in the splitter input register; its results are written
// to the response queue and shown on rsp from there. Throughput: one byte per
// cycle while the queue has room; a byte with both a frame record and the
// end-of-buffer summary gives two records. Reset is synchronous: splitter state,
// queue and handshakes clear, and max_frames returns to 100.
`default_nettype none
module crc_residue_frame_splitter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   crfs_req_if.sink         req_bus,
   crfs_rsp_if.source       rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]        max_frames_ff;
   logic               q_room;
   crfs_pkg::push_type push;

   // max_frames configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= crfs_pkg::MaxFramesReset;
      end else if (csr_we) begin
         max_frames_ff <= csr_wdata;
      end
   end

   crfs_splitter u_splitter (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .max_frames (max_frames_ff),
      .q_room     (q_room),
      .push       (push)
   );

   crfs_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_room  (q_room),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire
